/* hw/rtl/lagrange_interpolation_eval_top_macros.svh */
// assertion macros for the lagrange evaluator
// no dependencies
`ifndef LAGRANGE_INTERPOLATION_EVAL_TOP_MACROS_SVH
`define LAGRANGE_INTERPOLATION_EVAL_TOP_MACROS_SVH
`define LIE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

/* hw/rtl/lie_pkg.sv */
// shared types and constants for the lagrange evaluator
// no dependencies
package lie_pkg;
  localparam int unsigned MaxNodes = 8;
  localparam logic [1:0] ActClear = 2'd0;
  localparam logic [1:0] ActLoad = 2'd1;
  localparam logic [1:0] ActEval = 2'd2;
  localparam logic [62:0] MagLimit = 63'h3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic start;
    logic signed [63:0] w;
    logic signed [16:0] num;
    logic signed [16:0] den;
  } scale_req_t;

  typedef struct packed {
    logic done;
    logic clip;
    logic signed [63:0] w;
  } scale_rsp_t;
endpackage

/* hw/rtl/lagrange_interpolation_eval_top.sv */
// lagrange interpolation evaluator: node stores, sequencer and output register
// uses lie_pkg, lie_ram, lie_scale and the assertion macro header
// clear and a load below MaxNodes update the node count when accepted; evaluate checks
// the nodes and, with no duplicate x, runs one scale per ordered pair in the 79-step serial
// divider of lie_scale one item at a time; result held in an output register until taken
// rst_ni asynchronously clears the node count and control; stores are unset
`include "lagrange_interpolation_eval_top_macros.svh"
module lagrange_interpolation_eval_top #(
  parameter int unsigned MaxNodes = lie_pkg::MaxNodes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // action
  input  logic [47:0] s_axis_tdata,  // node_x, node_y, query_x
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // value
  output logic [2:0]  m_axis_tuser   // order_error, duplicate_error, saturated
);
  localparam int unsigned Aw = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned Cw = $clog2(MaxNodes + 1);

  typedef enum logic [8:0] {
    Idle = 9'b000000001, ChkRd = 9'b000000010, ChkCmp = 9'b000000100,
    IRd = 9'b000001000, JRd = 9'b000010000, JWait = 9'b000100000,
    Scale = 9'b001000000, Accum = 9'b010000000, Out = 9'b100000000
  } state_e;
  state_e state_q, state_d;

  logic [Cw-1:0] count_q;
  logic [Cw-1:0] i_q, j_q;
  logic [Aw-1:0] raddr;
  logic [15:0] xr, yr;
  logic signed [15:0] xi_q, q_q, xprev_q;
  logic ord_q, dup_q, clip_q;
  logic signed [63:0] w_q, acc_q;
  logic signed [64:0] sum;
  logic [47:0] val_q;
  logic [2:0] flg_q;
  logic ovalid_q;
  logic load;
  lie_pkg::scale_req_t sreq;
  lie_pkg::scale_rsp_t srsp;

  assign s_axis_tready = (state_q == Idle) && !ovalid_q;
  assign load = s_axis_tvalid && s_axis_tready && (s_axis_tuser == lie_pkg::ActLoad)
                && (count_q < Cw'(MaxNodes));

  always_comb begin
    raddr = i_q[Aw-1:0];
    if (state_q == JRd || state_q == ChkRd && i_q != j_q) raddr = j_q[Aw-1:0];
  end

  lie_ram #(.Width(16), .Depth(MaxNodes)) u_xram (
    .clk_i, .we_i(load), .waddr_i(count_q[Aw-1:0]), .wdata_i(s_axis_tdata[15:0]),
    .raddr_i(raddr), .rdata_o(xr));
  lie_ram #(.Width(16), .Depth(MaxNodes)) u_yram (
    .clk_i, .we_i(load), .waddr_i(count_q[Aw-1:0]), .wdata_i(s_axis_tdata[31:16]),
    .raddr_i(raddr), .rdata_o(yr));

  assign sreq.start = (state_q == JWait) && (j_q != i_q);
  assign sreq.w = w_q;
  assign sreq.num = 17'(q_q) - 17'($signed(xr));
  assign sreq.den = 17'(xi_q) - 17'($signed(xr));

  lie_scale u_scale (.clk_i, .rst_ni, .req_i(sreq), .rsp_o(srsp));

  assign sum = 65'(acc_q) + 65'(w_q);

  // check pass: i walks pairs (i, j>i) reading x[i] in ChkRd when j==i
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      Idle: if (s_axis_tvalid && s_axis_tready && s_axis_tuser == lie_pkg::ActEval)
              state_d = (count_q == '0) ? Out : ChkRd;
      ChkRd: state_d = ChkCmp;
      ChkCmp: begin
        if (j_q + Cw'(1) < count_q || j_q == i_q && i_q + Cw'(1) < count_q)
          state_d = ChkRd;
        else if (i_q + Cw'(2) < count_q) state_d = ChkRd;
        else state_d = dup_q || (i_q != j_q && xr == xi_q) ? Out : IRd;
      end
      IRd: state_d = JRd;
      JRd: state_d = JWait;
      JWait: state_d = (j_q != i_q) ? Scale
                     : (j_q + Cw'(1) < count_q) ? JRd : Accum;
      Scale: if (srsp.done) state_d = (j_q + Cw'(1) < count_q) ? JRd : Accum;
      Accum: state_d = (i_q + Cw'(1) < count_q) ? IRd : Out;
      Out: state_d = Idle;
      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      count_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_axis_tvalid && s_axis_tready && s_axis_tuser == lie_pkg::ActClear)
        count_q <= '0;
      else if (load) count_q <= count_q + Cw'(1);
      if (state_q == Out) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      Idle: begin
        q_q <= $signed(s_axis_tdata[47:32]);
        i_q <= '0; j_q <= '0;
        ord_q <= 1'b0; dup_q <= 1'b0; clip_q <= 1'b0; acc_q <= '0;
      end
      ChkRd: ;
      ChkCmp: begin
        if (j_q == i_q) begin
          xi_q <= $signed(xr);
          j_q <= i_q + Cw'(1);
        end else begin
          if (xr == xi_q) dup_q <= 1'b1;
          if (j_q == i_q + Cw'(1) && $signed(xr) < xi_q) ord_q <= 1'b1;
          if (j_q + Cw'(1) < count_q) j_q <= j_q + Cw'(1);
          else begin
            i_q <= (i_q + Cw'(2) < count_q) ? i_q + Cw'(1) : '0;
            j_q <= (i_q + Cw'(2) < count_q) ? i_q + Cw'(1) : '0;
          end
        end
      end
      IRd: j_q <= '0;
      JRd: if (j_q == '0) begin
        xi_q <= $signed(xr);
        w_q <= 64'($signed(yr)) <<< 16;
      end
      JWait: if (j_q == i_q) j_q <= j_q + Cw'(1);
      Scale: if (srsp.done) begin
        w_q <= srsp.w;
        clip_q <= clip_q | srsp.clip;
        j_q <= j_q + Cw'(1);
      end
      Accum: begin
        if (sum > 65'($signed({1'b0, lie_pkg::MagLimit}))) begin
          acc_q <= 64'($signed({1'b0, lie_pkg::MagLimit})); clip_q <= 1'b1;
        end else if (sum < -65'($signed({1'b0, lie_pkg::MagLimit}))) begin
          acc_q <= -64'($signed({1'b0, lie_pkg::MagLimit})); clip_q <= 1'b1;
        end else acc_q <= sum[63:0];
        i_q <= i_q + Cw'(1);
      end
      Out: begin
        if (dup_q) begin
          val_q <= '0; flg_q <= {1'b0, 1'b1, ord_q};
        end else if (acc_q > 64'sh7FFF_FFFF_FFFF) begin
          val_q <= 48'h7FFF_FFFF_FFFF; flg_q <= {1'b1, 1'b0, ord_q};
        end else if (acc_q < -64'sh8000_0000_0000) begin
          val_q <= 48'h8000_0000_0000; flg_q <= {1'b1, 1'b0, ord_q};
        end else begin
          val_q <= acc_q[47:0]; flg_q <= {clip_q, 1'b0, ord_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = val_q;
  assign m_axis_tuser = flg_q;

  `LIE_ASSERT(a_ready_idle, clk_i, rst_ni, s_axis_tready |-> state_q == Idle, "ready out of idle")
  `LIE_ASSERT(a_count_max, clk_i, rst_ni, count_q <= Cw'(MaxNodes), "node count overflow")
  `LIE_ASSERT(a_out_valid, clk_i, rst_ni, state_q == Out |=> m_axis_tvalid, "result lost")
endmodule

/* hw/rtl/lie_ram.sv */
// generic simple dual-port ram (separate write and read address) with registered read
// no dependencies
module lie_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hw/rtl/lie_scale.sv */
// shared scale unit: round(w * num / den) with magnitude clip
// a multiply step, then a 1-bit-per-cycle restoring divider; uses lie_pkg
module lie_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lie_pkg::scale_req_t req_i,
  output lie_pkg::scale_rsp_t rsp_o
);
  typedef enum logic [3:0] {
    SIdle = 4'b0001, SMul = 4'b0010, SDiv = 4'b0100, SFin = 4'b1000
  } sstate_e;
  sstate_e state_q, state_d;
  logic neg_q;
  logic [62:0] m_q;
  logic [15:0] d_q;
  logic [16:0] e_q;
  logic [78:0] quo_q;
  logic [17:0] rem_q;
  logic [6:0] cnt_q;
  logic signed [63:0] w_q;
  logic clip_q, done_q;
  logic [63:0] wabs;
  logic [16:0] nabs, dabs;
  logic [78:0] prod;
  logic [17:0] rsh;
  logic [62:0] v;
  logic over;

  assign wabs = req_i.w[63] ? 64'(-req_i.w) : 64'(req_i.w);
  assign nabs = req_i.num[16] ? 17'(-req_i.num) : 17'(req_i.num);
  assign dabs = req_i.den[16] ? 17'(-req_i.den) : 17'(req_i.den);
  assign prod = 79'(m_q) * 79'(d_q);
  assign rsh = {rem_q[16:0], quo_q[78]};
  assign over = (quo_q[78:63] != '0) || (quo_q[62:0] >= lie_pkg::MagLimit);
  assign v = over ? lie_pkg::MagLimit
                  : quo_q[62:0] + 63'({rem_q[16:0], 1'b0} >= {1'b0, e_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (req_i.start) state_d = SMul;
      SMul: state_d = SDiv;
      SDiv: if (cnt_q == 7'd78) state_d = SFin;
      SFin: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= (state_q == SFin);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SIdle: begin
        m_q <= wabs[62:0];
        d_q <= nabs[15:0];
        e_q <= dabs;
        neg_q <= req_i.w[63] ^ req_i.num[16] ^ req_i.den[16];
        cnt_q <= '0;
      end
      SMul: begin
        quo_q <= prod;
        rem_q <= '0;
      end
      SDiv: begin
        if (rsh >= {1'b0, e_q}) begin
          rem_q <= rsh - {1'b0, e_q};
          quo_q <= {quo_q[77:0], 1'b1};
        end else begin
          rem_q <= rsh;
          quo_q <= {quo_q[77:0], 1'b0};
        end
        cnt_q <= cnt_q + 7'd1;
      end
      SFin: begin
        w_q <= neg_q ? -$signed({1'b0, v}) : $signed({1'b0, v});
        clip_q <= over;
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.clip = clip_q;
  assign rsp_o.w = w_q;
endmodule

/* bench/testbench.sv */
// self-checking bench for lagrange_interpolation_eval_top: streams node loads,
// clears and evaluations, predicts each evaluation result and checks it
// depends on lie_pkg and the evaluator rtl
`timescale 1ns / 1ps
module testbench;
  localparam logic [1:0] ActNone = 2'd3;
  localparam int unsigned TailCycles = 6000;
  localparam logic [63:0] WeightLimit = {1'b0, lie_pkg::MagLimit};

  typedef struct {
    logic [1:0] action;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] qx;
  } op_t;

  typedef struct {
    logic [47:0] value;
    logic order_err;
    logic dup_err;
    logic sat;
  } interp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [1:0] s_axis_tuser = '0;   // action
  logic [47:0] s_axis_tdata = '0;  // node_x, node_y, query_x
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // value
  logic [2:0] m_axis_tuser;        // order_error, duplicate_error, saturated

  op_t pending_ops[$];
  interp_t expected_interp[$];
  int node_xs[lie_pkg::MaxNodes];
  int node_ys[lie_pkg::MaxNodes];
  int unsigned stored_nodes = 0;
  int unsigned errors = 0;
  int unsigned n_evals = 0;
  int unsigned n_checked = 0;
  int unsigned n_sat = 0;
  int unsigned n_dup = 0;
  bit op_taken = 1'b0;
  bit no_idle = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_gap = 0;

  lagrange_interpolation_eval_top u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // w * num / den rounded half away from zero, magnitude clipped
  function automatic longint scale_weight(input longint w, input int num, input int den,
                                          inout bit clip);
    logic [127:0] prod;
    logic [127:0] quo;
    logic [127:0] rem;
    logic [63:0] mag;
    logic [31:0] d;
    logic [31:0] e;
    bit neg;
    neg = (w < 0) ^ (num < 0) ^ (den < 0);
    mag = (w < 0) ? -w : w;
    d = (num < 0) ? -num : num;
    e = (den < 0) ? -den : den;
    prod = {64'd0, mag} * {96'd0, d};
    quo = prod / {96'd0, e};
    rem = prod % {96'd0, e};
    if (quo >= {64'd0, WeightLimit}) begin
      mag = WeightLimit;
      clip = 1'b1;
    end else begin
      mag = quo[63:0];
      if (2 * rem >= {96'd0, e}) mag = mag + 1;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic interp_t interpolate(input int qx);
    interp_t r;
    longint acc;
    longint w;
    bit clip;
    clip = 1'b0;
    acc = 0;
    r.order_err = 1'b0;
    r.dup_err = 1'b0;
    for (int i = 0; i + 1 < stored_nodes; i++)
      if (node_xs[i] > node_xs[i+1]) r.order_err = 1'b1;
    for (int i = 0; i < stored_nodes; i++)
      for (int j = i + 1; j < stored_nodes; j++)
        if (node_xs[i] == node_xs[j]) r.dup_err = 1'b1;
    if (!r.dup_err) begin
      for (int i = 0; i < stored_nodes; i++) begin
        w = longint'(node_ys[i]) * 65536;
        for (int j = 0; j < stored_nodes; j++)
          if (j != i) w = scale_weight(w, qx - node_xs[j], node_xs[i] - node_xs[j], clip);
        acc = acc + w;
        if (acc > longint'(WeightLimit)) begin
          acc = WeightLimit;
          clip = 1'b1;
        end
        if (acc < -longint'(WeightLimit)) begin
          acc = -longint'(WeightLimit);
          clip = 1'b1;
        end
      end
      if (acc > 64'sh7FFF_FFFF_FFFF) begin
        acc = 64'sh7FFF_FFFF_FFFF;
        clip = 1'b1;
      end
      if (acc < -64'sh8000_0000_0000) begin
        acc = -64'sh8000_0000_0000;
        clip = 1'b1;
      end
    end
    r.value = acc[47:0];
    r.sat = clip;
    return r;
  endfunction

  function automatic void apply_op(input op_t op);
    interp_t r;
    case (op.action)
      lie_pkg::ActClear: stored_nodes = 0;
      lie_pkg::ActLoad: begin
        if (stored_nodes < lie_pkg::MaxNodes) begin
          node_xs[stored_nodes] = int'($signed(op.nx));
          node_ys[stored_nodes] = int'($signed(op.ny));
          stored_nodes++;
        end
      end
      lie_pkg::ActEval: begin
        r = interpolate(int'($signed(op.qx)));
        expected_interp.push_back(r);
        n_evals++;
        if (r.sat) n_sat++;
        if (r.dup_err) n_dup++;
      end
      default: ;
    endcase
  endfunction

  function automatic void push_op(input logic [1:0] a, input int x, input int y, input int q);
    op_t op;
    op.action = a;
    op.nx = x[15:0];
    op.ny = y[15:0];
    op.qx = q[15:0];
    pending_ops.push_back(op);
  endfunction

  function automatic int rand16();
    return int'($signed(16'($urandom())));
  endfunction

  // at times an ignored op, then one clear, a node set of random shape and a few evaluations
  function automatic void push_frame();
    int xs[$];
    int n;
    int shape;
    int base;
    int step;
    int y;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 5);
    shape = $urandom_range(0, 5);
    base = $urandom_range(0, 1) ? rand16() : $urandom_range(0, 40) - 20;
    step = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      case (shape)
        0, 1: xs.push_back(rand16());
        default: xs.push_back(base + i * step);
      endcase
      if (xs[i] > 32767 || xs[i] < -32768) xs[i] = rand16();
    end
    if (shape == 1) xs.sort();
    if (shape == 5 && n > 1) xs[$urandom_range(1, n - 1)] = xs[0];
    if (shape == 4 && n > 1) xs.reverse();
    if ($urandom_range(0, 7) == 0) push_op(ActNone, rand16(), rand16(), rand16());
    push_op(lie_pkg::ActClear, rand16(), rand16(), rand16());
    foreach (xs[i]) begin
      y = $urandom_range(0, 2) == 0 ? rand16() : $urandom_range(0, 200) - 100;
      push_op(lie_pkg::ActLoad, xs[i], y, rand16());
    end
    for (int k = $urandom_range(1, 3); k > 0; k--)
      push_op(lie_pkg::ActEval, rand16(), rand16(),
              (n > 0 && $urandom_range(0, 1)) ? xs[0] + $urandom_range(0, 20) - 10 : rand16());
  endfunction

  // input side: one transaction per accepted op, predictor updated at the edge
  always @(posedge clk_i) begin
    op_taken <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) apply_op(pending_ops.pop_front());
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || op_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (!no_idle && op_taken && $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(1, 6) - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_ops[0].action;
        s_axis_tdata <= {pending_ops[0].qx, pending_ops[0].ny, pending_ops[0].nx};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side: random stall bursts on tready
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_gap > 0) begin
        stall_gap--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall_gap = $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    interp_t exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_interp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%h flags=%b", $time, m_axis_tdata, m_axis_tuser);
      end else begin
        exp_r = expected_interp.pop_front();
        n_checked++;
        if (m_axis_tdata !== exp_r.value) begin
          errors++;
          $display("%0t: value expected %h actual %h", $time, exp_r.value, m_axis_tdata);
        end
        if (m_axis_tuser[0] !== exp_r.order_err) begin
          errors++;
          $display("%0t: order_error expected %b actual %b", $time, exp_r.order_err,
                   m_axis_tuser[0]);
        end
        if (m_axis_tuser[1] !== exp_r.dup_err) begin
          errors++;
          $display("%0t: duplicate_error expected %b actual %b", $time, exp_r.dup_err,
                   m_axis_tuser[1]);
        end
        if (m_axis_tuser[2] !== exp_r.sat) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, exp_r.sat, m_axis_tuser[2]);
        end
      end
    end
  end

  initial begin
    // directed: empty set, extremes, full store, ignored load, order and duplicates
    push_op(lie_pkg::ActEval, 0, 0, 5);
    push_op(lie_pkg::ActLoad, -32768, 32767, 0);
    push_op(lie_pkg::ActEval, 0, 0, 32767);
    push_op(lie_pkg::ActLoad, 32767, -32768, 0);
    push_op(lie_pkg::ActEval, 0, 0, -32768);
    push_op(lie_pkg::ActEval, 0, 0, 0);
    push_op(lie_pkg::ActClear, 0, 0, 0);
    for (int i = 0; i < 8; i++)
      push_op(lie_pkg::ActLoad, i - 4, (i % 2) ? 32767 : -32768, 0);
    push_op(lie_pkg::ActLoad, 100, 1, 0);
    push_op(lie_pkg::ActEval, 0, 0, 32767);
    push_op(lie_pkg::ActEval, 0, 0, 1);
    push_op(ActNone, -1, -1, -1);
    push_op(lie_pkg::ActClear, 0, 0, 0);
    push_op(lie_pkg::ActLoad, 5, 3, 0);
    push_op(lie_pkg::ActLoad, -7, 9, 0);
    push_op(lie_pkg::ActLoad, 5, 1, 0);
    push_op(lie_pkg::ActEval, 0, 0, 2);
    while (pending_ops.size() < 750) push_frame();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    wait (rst_ni);
    wait (pending_ops.size() < 60);
    no_idle = 1'b1;
    wait (pending_ops.size() == 0 && expected_interp.size() == 0);
    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d evaluations, %0d checked, %0d saturated, %0d with duplicate x",
             n_evals, n_checked, n_sat, n_dup);
    if (errors == 0 && expected_interp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("timeout with %0d ops and %0d results outstanding", pending_ops.size(),
             expected_interp.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule
